// File: rtl/tpb_pkg.sv
// shared types and constants for the triangle pixel blend core
// no dependencies; imported by every module of the block
`default_nettype none

package tpb_pkg;

    localparam int COORD_W = 11;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    // area and edge sums, plus room for area - e0 - e1
    localparam int EDGE_W  = PROD_W + 3;
    localparam int PIX_W   = 8;
    localparam int COLOR_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [9:0] MAX_COLUMN = 10'd239;
    localparam logic [9:0] MAX_ROW    = 10'd134;

    localparam logic [COLOR_W-1:0] TEAL_ON_BLACK = 16'h016A;
    localparam logic [COLOR_W-1:0] FILL_RESET    = 16'h03FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_A_X = 3'd0,
        REG_VERTEX_A_Y = 3'd1,
        REG_VERTEX_B_X = 3'd2,
        REG_VERTEX_B_Y = 3'd3,
        REG_VERTEX_C_X = 3'd4,
        REG_VERTEX_C_Y = 3'd5,
        REG_FILL_COLOR = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COLOR_W-1:0] fill;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/tpb_cfg_regs.sv
// configuration register file: triangle corners and fill color
// depends on tpb_pkg
`default_nettype none

module tpb_cfg_regs
    import tpb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_VERTEX_A_X: cfg_next.ax   = cfg_data[COORD_W-1:0];
                REG_VERTEX_A_Y: cfg_next.ay   = cfg_data[COORD_W-1:0];
                REG_VERTEX_B_X: cfg_next.bx   = cfg_data[COORD_W-1:0];
                REG_VERTEX_B_Y: cfg_next.by   = cfg_data[COORD_W-1:0];
                REG_VERTEX_C_X: cfg_next.cx   = cfg_data[COORD_W-1:0];
                REG_VERTEX_C_Y: cfg_next.cy   = cfg_data[COORD_W-1:0];
                REG_FILL_COLOR: cfg_next.fill = cfg_data[COLOR_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ax   <= '0;
            cfg_reg.ay   <= '0;
            cfg_reg.bx   <= '0;
            cfg_reg.by   <= '0;
            cfg_reg.cx   <= '0;
            cfg_reg.cy   <= '0;
            cfg_reg.fill <= FILL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/tpb_edge.sv
// inside test: three integer edge functions against the doubled triangle area
// depends on tpb_pkg
`default_nettype none

module tpb_edge
    import tpb_pkg::*;
#(
    parameter logic [9:0] COLUMN_LIMIT = MAX_COLUMN,
    parameter logic [9:0] ROW_LIMIT    = MAX_ROW
)
(
    input  cfg_t                   cfg,
    input  wire logic [PIX_W-1:0]  px,
    input  wire logic [PIX_W-1:0]  py,
    output logic                   in_tri
);

    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, x, y;
    logic signed [DIFF_W-1:0] d_by_cy, d_cx_bx, d_cy_ay, d_ax_cx, d_ay_cy, d_x_cx, d_y_cy;
    logic signed [PROD_W-1:0] p_area0, p_area1, p_e00, p_e01, p_e10, p_e11;
    logic signed [EDGE_W-1:0] area, e0, e1, e2;
    logic                     on_screen;
    logic                     all_pos, all_neg;

    always_comb
    begin
        ax = $signed({cfg.ax[COORD_W-1], cfg.ax});
        ay = $signed({cfg.ay[COORD_W-1], cfg.ay});
        bx = $signed({cfg.bx[COORD_W-1], cfg.bx});
        by = $signed({cfg.by[COORD_W-1], cfg.by});
        cx = $signed({cfg.cx[COORD_W-1], cfg.cx});
        cy = $signed({cfg.cy[COORD_W-1], cfg.cy});
        x  = $signed({{(DIFF_W-PIX_W){1'b0}}, px});
        y  = $signed({{(DIFF_W-PIX_W){1'b0}}, py});

        // pixel offsets stay inside 12 bits since pixels are at most 255
        d_by_cy = by - cy;
        d_cx_bx = cx - bx;
        d_cy_ay = cy - ay;
        d_ax_cx = ax - cx;
        d_ay_cy = ay - cy;
        d_x_cx  = x - cx;
        d_y_cy  = y - cy;

        p_area0 = d_by_cy * d_ax_cx;
        p_area1 = d_cx_bx * d_ay_cy;
        p_e00   = d_by_cy * d_x_cx;
        p_e01   = d_cx_bx * d_y_cy;
        p_e10   = d_cy_ay * d_x_cx;
        p_e11   = d_ax_cx * d_y_cy;

        area = EDGE_W'(p_area0) + EDGE_W'(p_area1);
        e0   = EDGE_W'(p_e00) + EDGE_W'(p_e01);
        e1   = EDGE_W'(p_e10) + EDGE_W'(p_e11);
        e2   = area - e0 - e1;

        on_screen = ({2'b00, px} <= COLUMN_LIMIT) && ({2'b00, py} <= ROW_LIMIT);
        all_pos   = !e0[EDGE_W-1] && !e1[EDGE_W-1] && !e2[EDGE_W-1];
        all_neg   = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);

        // zero area is degenerate and never writes
        priority if (area > 0)
            in_tri = on_screen && all_pos;
        else if (area < 0)
            in_tri = on_screen && all_neg;
        else
            in_tri = 1'b0;
    end

endmodule

`default_nettype wire

// File: rtl/tpb_blend.sv
// rgb565 blend: background outside the triangle; inside, teal on black, otherwise (3*bg + fg) / 4 per channel
// depends on tpb_pkg
`default_nettype none

module tpb_blend
    import tpb_pkg::*;
(
    input  wire logic [COLOR_W-1:0] bg,
    input  wire logic [COLOR_W-1:0] fg,
    input  wire logic               in_tri,
    output logic [COLOR_W-1:0]      pixel
);

    logic [6:0] r_sum, b_sum;
    logic [7:0] g_sum;
    logic [COLOR_W-1:0] mixed;

    always_comb
    begin
        r_sum = 7'({bg[15:11], 1'b0}) + 7'(bg[15:11]) + 7'(fg[15:11]);
        g_sum = 8'({bg[10:5], 1'b0}) + 8'(bg[10:5]) + 8'(fg[10:5]);
        b_sum = 7'({bg[4:0], 1'b0}) + 7'(bg[4:0]) + 7'(fg[4:0]);
        mixed = {r_sum[6:2], g_sum[7:2], b_sum[6:2]};

        if (!in_tri)
            pixel = bg;
        else if (bg == '0)
            pixel = TEAL_ON_BLACK;
        else
            pixel = mixed;
    end

endmodule

`default_nettype wire

// File: rtl/triangle_pixel_blend_core.sv
// top level of the triangle pixel blend core: pixel register, test and blend, result register
// depends on tpb_pkg, tpb_cfg_regs, tpb_edge, tpb_blend
//
//   channel   direction  handshake                   payload
//   pixel     in         pixel_valid / pixel_stall   pixel_x, pixel_y, background_pixel
//   result    out        result_valid / result_stall out_x, out_y, write_enable, new_pixel
//   config    in         cfg_we                      cfg_index, cfg_data
//
// one request per cycle sustained while result_stall is low; an accepted request waits in
// the pixel register while the edge multipliers and blend settle into the result register,
// which drives the output and loads anew once it is empty or being taken
// reset clears the valid flags and loads the register defaults (fill color 0x03ff)
// a stalled result holds the result register; the pixel register keeps taking
// requests until both stages are full
`default_nettype none

module triangle_pixel_blend_core
    import tpb_pkg::*;
#(
    parameter logic [9:0] COLUMN_LIMIT = MAX_COLUMN,
    parameter logic [9:0] ROW_LIMIT    = MAX_ROW
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire logic [PIX_W-1:0]      pixel_x,
    input  wire logic [PIX_W-1:0]      pixel_y,
    input  wire logic [COLOR_W-1:0]    background_pixel,

    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [PIX_W-1:0]           out_x,
    output logic [PIX_W-1:0]           out_y,
    output logic                       write_enable,
    output logic [COLOR_W-1:0]         new_pixel
);

    cfg_t cfg;

    logic                s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]    s1_x_reg, s1_y_reg;
    logic [COLOR_W-1:0]  s1_bg_reg;

    logic                res_valid_reg, res_valid_next;
    logic [PIX_W-1:0]    res_x_reg, res_y_reg;
    logic                res_we_reg;
    logic [COLOR_W-1:0]  res_pixel_reg;

    logic                res_load;
    logic                s1_load;
    logic                in_tri;
    logic [COLOR_W-1:0]  blended;

    tpb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpb_edge #(
        .COLUMN_LIMIT (COLUMN_LIMIT),
        .ROW_LIMIT    (ROW_LIMIT)
    ) u_edge (
        .cfg    (cfg),
        .px     (s1_x_reg),
        .py     (s1_y_reg),
        .in_tri (in_tri)
    );

    tpb_blend u_blend (
        .bg     (s1_bg_reg),
        .fg     (cfg.fill),
        .in_tri (in_tri),
        .pixel  (blended)
    );

    // result register frees up when empty or being taken
    assign res_load    = !res_valid_reg || !result_stall;
    assign pixel_stall = s1_valid_reg && !res_load;
    assign s1_load     = pixel_valid && !pixel_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (res_load)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg  <= pixel_x;
            s1_y_reg  <= pixel_y;
            s1_bg_reg <= background_pixel;
        end
        if (res_load && s1_valid_reg)
        begin
            res_x_reg     <= s1_x_reg;
            res_y_reg     <= s1_y_reg;
            res_we_reg    <= in_tri;
            res_pixel_reg <= blended;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_x        = res_x_reg;
    assign out_y        = res_y_reg;
    assign write_enable = res_we_reg;
    assign new_pixel    = res_pixel_reg;

endmodule

`default_nettype wire

// File: rtl/tpb_checker.sv
// port-level checks for the triangle pixel blend core, bound to the top level
// depends on tpb_pkg and triangle_pixel_blend_core
`default_nettype none

module tpb_checker
    import tpb_pkg::*;
#(
    parameter logic [9:0] COLUMN_LIMIT = MAX_COLUMN,
    parameter logic [9:0] ROW_LIMIT    = MAX_ROW
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pixel_valid,
    input wire logic               pixel_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire logic [PIX_W-1:0]   out_x,
    input wire logic [PIX_W-1:0]   out_y,
    input wire logic               write_enable,
    input wire logic [COLOR_W-1:0] new_pixel
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(out_x) && $stable(out_y)
            && $stable(write_enable) && $stable(new_pixel))
        else $error("stalled result changed");

    // off-screen pixels are never written
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && write_enable |->
            ({2'b00, out_x} <= COLUMN_LIMIT) && ({2'b00, out_y} <= ROW_LIMIT))
        else $error("write outside the screen");

    // input back-pressure only when both stages hold a request
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> result_valid && result_stall)
        else $error("pixel stalled with a free result stage");

    // an accepted request reaches the result port unless the result stage is stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) ##1 !result_stall |=> result_valid)
        else $error("accepted request did not reach the result register");

endmodule

bind triangle_pixel_blend_core tpb_checker #(
    .COLUMN_LIMIT (COLUMN_LIMIT),
    .ROW_LIMIT    (ROW_LIMIT)
) u_tpb_checker (.*);

`default_nettype wire

// File: tb/tb_triangle_pixel_blend_core.sv
// self-checking testbench for triangle_pixel_blend_core: directed triangles, back pressure, then
// random triangle scans under several idle and stall patterns; depends on tpb_pkg and the core rtl
`timescale 1ns / 1ps

module tb_triangle_pixel_blend_core;

    import tpb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 3;
    localparam int SHOW_LIMIT   = 10;

    // no register lives at this index
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic               we;
        logic [COLOR_W-1:0] pix;
    } pixel_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_W-1:0]    background_pixel;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [PIX_W-1:0]      out_x;
    logic [PIX_W-1:0]      out_y;
    logic                  write_enable;
    logic [COLOR_W-1:0]    new_pixel;

    cfg_t         triangle_cfg;
    pixel_write_t expected_writes[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_req        = 1'b0;
    bit hold_ack;
    int hold_left;

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int pixels_written  = 0;
    int triangles_set   = 0;

    triangle_pixel_blend_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel_x          (pixel_x),
        .pixel_y          (pixel_y),
        .background_pixel (background_pixel),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .out_x            (out_x),
        .out_y            (out_y),
        .write_enable     (write_enable),
        .new_pixel        (new_pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int mix_quarter(input int bg_chan, input int fg_chan);
        return (3 * bg_chan + fg_chan) >> 2;
    endfunction

    function automatic pixel_write_t predict_blend(input cfg_t c, input logic [PIX_W-1:0] px,
            input logic [PIX_W-1:0] py, input logic [COLOR_W-1:0] bg);
        longint ax, ay, bx, by, cx, cy, x, y;
        longint area, e0, e1, e2;
        bit hit;
        int r, g, b;
        pixel_write_t res;
        ax = $signed(c.ax);
        ay = $signed(c.ay);
        bx = $signed(c.bx);
        by = $signed(c.by);
        cx = $signed(c.cx);
        cy = $signed(c.cy);
        x = px;
        y = py;
        area = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
        e0 = (by - cy) * (x - cx) + (cx - bx) * (y - cy);
        e1 = (cy - ay) * (x - cx) + (ax - cx) * (y - cy);
        e2 = area - e0 - e1;
        // edge functions must agree in sign with the doubled area, zero counts as inside
        hit = 1'b0;
        if (area > 0)
            hit = (e0 >= 0) && (e1 >= 0) && (e2 >= 0);
        else if (area < 0)
            hit = (e0 <= 0) && (e1 <= 0) && (e2 <= 0);
        if (px > MAX_COLUMN || py > MAX_ROW)
            hit = 1'b0;
        res.x   = px;
        res.y   = py;
        res.we  = hit;
        res.pix = bg;
        if (hit && bg == '0)
            res.pix = TEAL_ON_BLACK;
        else if (hit)
        begin
            r = mix_quarter(bg[15:11], c.fill[15:11]);
            g = mix_quarter(bg[10:5], c.fill[10:5]);
            b = mix_quarter(bg[4:0], c.fill[4:0]);
            res.pix = {r[4:0], g[5:0], b[4:0]};
        end
        return res;
    endfunction

    // receiver: random stalls, or a long hold-off when the test toggles hold_req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_ack     <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // outputs are steady mid-cycle, so a result seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        pixel_write_t got;
        pixel_write_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{x: out_x, y: out_y, we: write_enable, pix: new_pixel};
            results_checked++;
            pixels_written += got.we;
            if (expected_writes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("%0t: unexpected result x=%0d y=%0d we=%0b pix=%h",
                             $time, got.x, got.y, got.we, got.pix);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.we !== want.we
                        || got.pix !== want.pix)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: expected x=%0d y=%0d we=%0b pix=%h, got x=%0d y=%0d we=%0b pix=%h",
                                 $time, want.x, want.y, want.we, want.pix,
                                 got.x, got.y, got.we, got.pix);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_writes.size());
        $display("tb_triangle_pixel_blend_core NOT OK");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                              input logic [COLOR_W-1:0] bg);
        bit taken;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid      <= 1'b1;
        pixel_x          <= x;
        pixel_y          <= y;
        background_pixel <= bg;
        do
        begin
            @(negedge clk);
            taken = !pixel_stall;
            @(posedge clk);
        end
        while (!taken);
        expected_writes.push_back(predict_blend(triangle_cfg, x, y, bg));
        requests_sent++;
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic wait_for_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_VERTEX_A_X: triangle_cfg.ax = data[COORD_W-1:0];
            REG_VERTEX_A_Y: triangle_cfg.ay = data[COORD_W-1:0];
            REG_VERTEX_B_X: triangle_cfg.bx = data[COORD_W-1:0];
            REG_VERTEX_B_Y: triangle_cfg.by = data[COORD_W-1:0];
            REG_VERTEX_C_X: triangle_cfg.cx = data[COORD_W-1:0];
            REG_VERTEX_C_Y: triangle_cfg.cy = data[COORD_W-1:0];
            REG_FILL_COLOR: triangle_cfg.fill = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits are junk, vertex registers keep only the low eleven
    task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                                input int cx, input int cy);
        write_reg(REG_VERTEX_A_X, {5'($urandom), 11'(ax)});
        write_reg(REG_VERTEX_A_Y, {5'($urandom), 11'(ay)});
        write_reg(REG_VERTEX_B_X, {5'($urandom), 11'(bx)});
        write_reg(REG_VERTEX_B_Y, {5'($urandom), 11'(by)});
        write_reg(REG_VERTEX_C_X, {5'($urandom), 11'(cx)});
        write_reg(REG_VERTEX_C_Y, {5'($urandom), 11'(cy)});
        triangles_set++;
    endtask

    function automatic int pick_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return int'($urandom_range(0, 320)) - 40;
        else if (sel < 85)
            return int'($urandom_range(0, 2047)) - 1024;
        else if (sel < 92)
            return -1024;
        return 1023;
    endfunction

    // all corners at zero after reset: nothing may be written
    task automatic test_reset_state();
        send_pixel(8'd0, 8'd0, 16'h0000);
        send_pixel(8'd239, 8'd134, 16'hFFFF);
        send_pixel(8'd5, 8'd5, 16'h5A5A);
    endtask

    task automatic test_inside_and_edges();
        // fill still holds its reset value here
        set_triangle(10, 10, 200, 10, 10, 120);
        send_pixel(8'd50, 8'd50, 16'h1234);
        send_pixel(8'd50, 8'd50, 16'h0000);
        send_pixel(8'd10, 8'd10, 16'hFFFF);
        send_pixel(8'd200, 8'd10, 16'h8410);
        send_pixel(8'd10, 8'd120, 16'h0001);
        send_pixel(8'd100, 8'd10, 16'hF800);
        send_pixel(8'd105, 8'd65, 16'h07E0);
        send_pixel(8'd9, 8'd10, 16'h001F);
        send_pixel(8'd106, 8'd65, 16'hABCD);
        send_pixel(8'd150, 8'd100, 16'h5555);
        // same triangle wound the other way, negative area
        write_reg(REG_FILL_COLOR, 16'hFFFF);
        set_triangle(10, 10, 10, 120, 200, 10);
        send_pixel(8'd50, 8'd50, 16'h1234);
        send_pixel(8'd10, 8'd120, 16'h0000);
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED, 16'h0000);
        send_pixel(8'd50, 8'd50, 16'h1234);
    endtask

    // a triangle at the coordinate extremes that covers the whole 8-bit pixel range
    task automatic test_screen_limits();
        write_reg(REG_FILL_COLOR, 16'h0000);
        set_triangle(-1024, -1024, 1023, -1024, 0, 1023);
        send_pixel(8'd0, 8'd0, 16'hFFFF);
        send_pixel(8'd239, 8'd134, 16'hFFFF);
        send_pixel(8'd240, 8'd50, 16'h1111);
        send_pixel(8'd50, 8'd135, 16'h2222);
        send_pixel(8'd255, 8'd255, 16'h3333);
        set_triangle(1023, 1023, -1024, 1023, 1023, -1024);
        send_pixel(8'd128, 8'd64, 16'h8000);
    endtask

    task automatic test_degenerate();
        set_triangle(0, 0, 100, 100, 200, 200);
        send_pixel(8'd50, 8'd50, 16'h4321);
        send_pixel(8'd0, 8'd0, 16'h0000);
    endtask

    // receiver holds off while requests keep coming, so the input side must stall
    task automatic test_backpressure();
        int n;
        write_reg(REG_FILL_COLOR, 16'($urandom));
        set_triangle(0, 0, 239, 0, 0, 134);
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_req       <= ~hold_req;
        for (n = 0; n < 40; n++)
            send_pixel(8'($urandom_range(0, 150)), 8'($urandom_range(0, 140)), 16'($urandom));
        wait_for_results();
    endtask

    task automatic test_random_scenes(input int idle_pct, input int stall_pct, input int count);
        int ax, ay, bx, by, cx, cy;
        int lo_x, hi_x, lo_y, hi_y;
        int sent, batch, n, sel;
        logic [PIX_W-1:0] px, py;
        logic [COLOR_W-1:0] bg;
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        sent = 0;
        while (sent < count)
        begin
            ax = pick_coord();
            ay = pick_coord();
            bx = pick_coord();
            by = pick_coord();
            cx = pick_coord();
            cy = pick_coord();
            sel = $urandom_range(0, 19);
            // collapsed triangles: a repeated corner or three corners on one row
            if (sel == 0)
            begin
                cx = ax;
                cy = ay;
            end
            else if (sel == 1)
            begin
                by = ay;
                cy = ay;
            end
            sel = $urandom_range(0, 9);
            if (sel == 0)
                write_reg(REG_FILL_COLOR, 16'h0000);
            else if (sel == 1)
                write_reg(REG_FILL_COLOR, 16'hFFFF);
            else
                write_reg(REG_FILL_COLOR, 16'($urandom));
            set_triangle(ax, ay, bx, by, cx, cy);
            // bounding box clipped to what the pixel fields can express
            lo_x = ax < bx ? ax : bx;
            lo_x = cx < lo_x ? cx : lo_x;
            hi_x = ax > bx ? ax : bx;
            hi_x = cx > hi_x ? cx : hi_x;
            lo_y = ay < by ? ay : by;
            lo_y = cy < lo_y ? cy : lo_y;
            hi_y = ay > by ? ay : by;
            hi_y = cy > hi_y ? cy : hi_y;
            lo_x = lo_x < 0 ? 0 : lo_x;
            lo_y = lo_y < 0 ? 0 : lo_y;
            hi_x = hi_x > 255 ? 255 : hi_x;
            hi_y = hi_y > 255 ? 255 : hi_y;
            batch = $urandom_range(20, 60);
            for (n = 0; n < batch; n++)
            begin
                if ($urandom_range(0, 3) != 0 && lo_x <= hi_x && lo_y <= hi_y)
                begin
                    px = 8'($urandom_range(lo_x, hi_x));
                    py = 8'($urandom_range(lo_y, hi_y));
                end
                else
                begin
                    px = 8'($urandom);
                    py = 8'($urandom);
                end
                sel = $urandom_range(0, 19);
                if (sel < 2)
                    bg = 16'h0000;
                else if (sel == 2)
                    bg = 16'hFFFF;
                else
                    bg = 16'($urandom);
                send_pixel(px, py, bg);
            end
            sent += batch;
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        pixel_valid      <= 1'b0;
        pixel_x          <= '0;
        pixel_y          <= '0;
        background_pixel <= '0;
        triangle_cfg = '{ax: '0, ay: '0, bx: '0, by: '0, cx: '0, cy: '0, fill: FILL_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_inside_and_edges();
        test_unused_index();
        test_screen_limits();
        test_degenerate();
        test_backpressure();
        test_random_scenes(0, 0, 440);
        test_random_scenes(54, 0, 440);
        test_random_scenes(0, 54, 440);
        test_random_scenes(10, 10, 440);

        wait_for_results();
        repeat (4) @(posedge clk);

        $display("%0d pixel requests over %0d triangles, %0d results checked, %0d written",
                 requests_sent, triangles_set, results_checked, pixels_written);
        $display("directed corners, edges, screen limits, collapsed triangles; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("tb_triangle_pixel_blend_core OK");
        else
            $display("tb_triangle_pixel_blend_core NOT OK");
        $finish;
    end

endmodule
